// File: hdl/speq_pkg.sv
// Package for the stable priority event queue.
// Holds the queue depth, entry and command types and outcome codes.
// Depends on nothing; every other file of the block uses it.
package speq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_WIDTH   = 5;

   typedef logic [1:0] outcome_type;
   localparam outcome_type OUTCOME_PUSHED    = 2'd0;
   localparam outcome_type OUTCOME_POPPED    = 2'd1;
   localparam outcome_type OUTCOME_POP_EMPTY = 2'd2;
   localparam outcome_type OUTCOME_PUSH_FULL = 2'd3;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic [7:0]  prio;
      logic [7:0]  status;
      logic [15:0] amount;
      logic [7:0]  system_tag;
      logic [7:0]  resource_tag;
   } entry_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP,
      OP_FULL,
      OP_EMPTY
   } op_type;

   typedef struct packed {
      logic   capture;
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
   } dp_status_type;

endpackage

// File: hdl/speq_ctrl.sv
// Controller of the stable priority event queue.
// Sequences capture and execution of one transaction and raises the result strobe.
// Depends on speq_pkg.
module speq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output speq_pkg::dp_cmd_type    cmd,
   input  speq_pkg::dp_status_type status
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in    = state_ff;
      busy_in     = busy_ff;
      valid_in    = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = speq_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
               busy_in     = 1'b1;
            end
         end
         ST_EXEC: begin
            priority if (status.is_pop && status.empty) begin
               cmd.op = speq_pkg::OP_EMPTY;
            end else if (status.is_pop) begin
               cmd.op = speq_pkg::OP_POP;
            end else if (status.full) begin
               cmd.op = speq_pkg::OP_FULL;
            end else begin
               cmd.op = speq_pkg::OP_PUSH;
            end
            state_in = ST_IDLE;
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

// File: hdl/speq_dp.sv
// Datapath of the stable priority event queue.
// Holds the sorted register array with per-slot compare and shift, the count and
// the result registers. Depends on speq_pkg.
module speq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  speq_pkg::dp_cmd_type                 cmd,
   output speq_pkg::dp_status_type              status,
   input  logic                                 req_kind,
   input  logic [7:0]                           req_priority_req,
   input  logic [7:0]                           req_event_status,
   input  logic [15:0]                          req_amount,
   input  logic [7:0]                           req_system_tag,
   input  logic [7:0]                           req_resource_tag,
   output speq_pkg::outcome_type                rsp_outcome,
   output speq_pkg::entry_type                  rsp_entry,
   output logic [speq_pkg::OCC_WIDTH-1:0]       rsp_occupancy,
   output logic [speq_pkg::COUNT_WIDTH-1:0]     count
);

   localparam int Depth = speq_pkg::QUEUE_DEPTH;
   localparam int CntW  = speq_pkg::COUNT_WIDTH;

   logic                   kind_ff;
   speq_pkg::entry_type    fresh_ff;
   speq_pkg::entry_type    store_ff [Depth];
   speq_pkg::entry_type    store_in [Depth];
   speq_pkg::entry_type    prev_entry [Depth];
   speq_pkg::entry_type    next_entry [Depth];
   logic [Depth-1:0]       ge;
   logic [Depth-1:0]       ge_prev;
   logic [CntW-1:0]        count_ff, count_in;
   speq_pkg::outcome_type  outcome_ff;
   speq_pkg::entry_type    out_entry_ff;
   logic [speq_pkg::OCC_WIDTH-1:0] occ_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff                <= req_kind;
         fresh_ff.prio          <= req_priority_req;
         fresh_ff.status        <= req_event_status;
         fresh_ff.amount        <= req_amount;
         fresh_ff.system_tag    <= req_system_tag;
         fresh_ff.resource_tag  <= req_resource_tag;
      end
   end

   assign status.is_pop = (kind_ff == speq_pkg::KIND_POP);
   assign status.empty  = (count_ff == '0);
   assign status.full   = (count_ff == CntW'(Depth));

   for (genvar i = 0; i < Depth; i++) begin : g_slot
      assign ge[i] = (CntW'(i) < count_ff) && (store_ff[i].prio >= fresh_ff.prio);
      if (i == 0) begin : g_head
         assign ge_prev[i]    = 1'b1;
         assign prev_entry[i] = fresh_ff;
      end else begin : g_body
         assign ge_prev[i]    = ge[i-1];
         assign prev_entry[i] = store_ff[i-1];
      end
      if (i == Depth - 1) begin : g_tail
         assign next_entry[i] = store_ff[i];
      end else begin : g_inner
         assign next_entry[i] = store_ff[i+1];
      end
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < Depth; i++) begin
         store_in[i] = store_ff[i];
      end
      unique case (cmd.op)
         speq_pkg::OP_PUSH: begin
            for (int i = 0; i < Depth; i++) begin
               if (!ge[i]) begin
                  store_in[i] = ge_prev[i] ? fresh_ff : prev_entry[i];
               end
            end
            count_in = count_ff + CntW'(1);
         end
         speq_pkg::OP_POP: begin
            for (int i = 0; i < Depth; i++) begin
               store_in[i] = next_entry[i];
            end
            count_in = count_ff - CntW'(1);
         end
         speq_pkg::OP_NONE, speq_pkg::OP_FULL, speq_pkg::OP_EMPTY: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Depth; i++) begin
         store_ff[i] <= store_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op != speq_pkg::OP_NONE) begin
         unique case (cmd.op)
            speq_pkg::OP_PUSH:  outcome_ff <= speq_pkg::OUTCOME_PUSHED;
            speq_pkg::OP_POP:   outcome_ff <= speq_pkg::OUTCOME_POPPED;
            speq_pkg::OP_EMPTY: outcome_ff <= speq_pkg::OUTCOME_POP_EMPTY;
            speq_pkg::OP_FULL:  outcome_ff <= speq_pkg::OUTCOME_PUSH_FULL;
            default:            outcome_ff <= speq_pkg::OUTCOME_PUSH_FULL;
         endcase
         out_entry_ff <= (cmd.op == speq_pkg::OP_POP) ? store_ff[0] : '0;
         occ_ff       <= speq_pkg::OCC_WIDTH'(count_in);
      end
   end

   assign rsp_outcome   = outcome_ff;
   assign rsp_entry     = out_entry_ff;
   assign rsp_occupancy = occ_ff;
   assign count         = count_ff;

endmodule

// File: hdl/stable_priority_event_queue.sv
// Top level of the stable priority event queue.
// Joins speq_ctrl and speq_dp and carries the assertions. Depends on speq_pkg.
//
//   Channel   Handshake            Ports
//   request   start, busy          req_kind, req_priority_req, req_event_status,
//                                  req_amount, req_system_tag, req_resource_tag
//   response  rsp_valid (strobe)   rsp_outcome, rsp_out_priority, rsp_out_status,
//                                  rsp_out_amount, rsp_out_system_tag,
//                                  rsp_out_resource_tag, rsp_occupancy
//
// A transaction is accepted when start is high and busy is low; busy is then high for
// one cycle while the sorted register array compares every slot in parallel and shifts.
// The result strobe follows in the next cycle, when busy is already low again, so a
// new transaction can be taken while the strobe is high. Synchronous reset empties
// the queue at once. The receiver cannot stall, so results never wait.
module stable_priority_event_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [7:0]                      req_priority_req,
   input  logic [7:0]                      req_event_status,
   input  logic [15:0]                     req_amount,
   input  logic [7:0]                      req_system_tag,
   input  logic [7:0]                      req_resource_tag,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_outcome,
   output logic [7:0]                      rsp_out_priority,
   output logic [7:0]                      rsp_out_status,
   output logic [15:0]                     rsp_out_amount,
   output logic [7:0]                      rsp_out_system_tag,
   output logic [7:0]                      rsp_out_resource_tag,
   output logic [4:0]                      rsp_occupancy
);

   speq_pkg::dp_cmd_type                cmd;
   speq_pkg::dp_status_type             status;
   speq_pkg::entry_type                 entry;
   logic [speq_pkg::COUNT_WIDTH-1:0]    count;

   speq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   speq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_event_status (req_event_status),
      .req_amount       (req_amount),
      .req_system_tag   (req_system_tag),
      .req_resource_tag (req_resource_tag),
      .rsp_outcome      (rsp_outcome),
      .rsp_entry        (entry),
      .rsp_occupancy    (rsp_occupancy),
      .count            (count)
   );

   assign rsp_out_priority     = entry.prio;
   assign rsp_out_status       = entry.status;
   assign rsp_out_amount       = entry.amount;
   assign rsp_out_system_tag   = entry.system_tag;
   assign rsp_out_resource_tag = entry.resource_tag;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transaction did not raise busy");

   a_strobe_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe without a transaction in progress");

   a_occupancy_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy == speq_pkg::OCC_WIDTH'(count)))
      else $error("reported occupancy differs from stored count");

   a_no_pop_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome != speq_pkg::OUTCOME_POPPED)) |->
      (entry == '0))
      else $error("event fields not zero on a result without a pop");

endmodule

// File: bench/speq_checker.sv
// Checker for the stable priority event queue: watches both channels, keeps its own
// sorted copy of the queue and compares every response with the predicted one.
// Depends on speq_pkg for the entry type, outcome codes and queue depth.
module speq_checker
   import speq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_kind,
   input  logic [7:0]  req_priority_req,
   input  logic [7:0]  req_event_status,
   input  logic [15:0] req_amount,
   input  logic [7:0]  req_system_tag,
   input  logic [7:0]  req_resource_tag,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_outcome,
   input  logic [7:0]  rsp_out_priority,
   input  logic [7:0]  rsp_out_status,
   input  logic [15:0] rsp_out_amount,
   input  logic [7:0]  rsp_out_system_tag,
   input  logic [7:0]  rsp_out_resource_tag,
   input  logic [4:0]  rsp_occupancy,
   output int          mismatch_count,
   output int          replies_awaited,
   output int          stored_count,
   output int          popped_count,
   output int          empty_pop_count,
   output int          dropped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      outcome_type          outcome;
      entry_type            ev;
      logic [OCC_WIDTH-1:0] occupancy;
   } queue_reply_type;

   entry_type       shadow_entries [QUEUE_DEPTH];
   int              shadow_count;
   queue_reply_type replies_due [$];

   initial begin
      mismatch_count  = 0;
      replies_awaited = 0;
      stored_count    = 0;
      popped_count    = 0;
      empty_pop_count = 0;
      dropped_count   = 0;
      shadow_count    = 0;
   end

   // Applies one transaction to the shadow queue and returns the response it must give.
   function automatic queue_reply_type apply_event(logic kind, entry_type fresh);
      queue_reply_type reply;
      int              slot;
      reply = '0;
      if (kind == KIND_PUSH) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            reply.outcome = OUTCOME_PUSH_FULL;
         end else begin
            slot = 0;
            while (slot < shadow_count && shadow_entries[slot].prio >= fresh.prio)
               slot++;
            for (int k = shadow_count; k > slot; k--)
               shadow_entries[k] = shadow_entries[k - 1];
            shadow_entries[slot] = fresh;
            shadow_count++;
            reply.outcome = OUTCOME_PUSHED;
         end
      end else begin
         if (shadow_count == 0) begin
            reply.outcome = OUTCOME_POP_EMPTY;
         end else begin
            reply.ev = shadow_entries[0];
            for (int k = 1; k < shadow_count; k++)
               shadow_entries[k - 1] = shadow_entries[k];
            shadow_count--;
            reply.outcome = OUTCOME_POPPED;
         end
      end
      reply.occupancy = shadow_count[OCC_WIDTH-1:0];
      return reply;
   endfunction

   task automatic compare_field(string field_name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field_name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_reply_type due;
      entry_type       fresh;
      if (reset) begin
         shadow_count = 0;
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual outcome %0d",
                        $time, rsp_outcome);
               mismatch_count++;
            end else begin
               due = replies_due.pop_front();
               compare_field("outcome", due.outcome, rsp_outcome);
               compare_field("out_priority", due.ev.prio, rsp_out_priority);
               compare_field("out_status", due.ev.status, rsp_out_status);
               compare_field("out_amount", due.ev.amount, rsp_out_amount);
               compare_field("out_system_tag", due.ev.system_tag, rsp_out_system_tag);
               compare_field("out_resource_tag", due.ev.resource_tag, rsp_out_resource_tag);
               compare_field("occupancy", due.occupancy, rsp_occupancy);
               case (due.outcome)
                  OUTCOME_PUSHED:    stored_count++;
                  OUTCOME_POPPED:    popped_count++;
                  OUTCOME_POP_EMPTY: empty_pop_count++;
                  default:           dropped_count++;
               endcase
            end
         end
         if (start && !busy) begin
            fresh.prio         = req_priority_req;
            fresh.status       = req_event_status;
            fresh.amount       = req_amount;
            fresh.system_tag   = req_system_tag;
            fresh.resource_tag = req_resource_tag;
            replies_due.push_back(apply_event(req_kind, fresh));
         end
      end
      replies_awaited = replies_due.size();
   end

endmodule

// File: bench/testbench.sv
// Top of the bench for the stable priority event queue: clock, reset, directed and
// random push and pop transactions, watchdog and verdict.
// Depends on speq_pkg, stable_priority_event_queue and speq_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import speq_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 950;
   localparam int PHASES       = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = KIND_PUSH;
   logic [7:0]  req_priority_req = '0;
   logic [7:0]  req_event_status = '0;
   logic [15:0] req_amount = '0;
   logic [7:0]  req_system_tag = '0;
   logic [7:0]  req_resource_tag = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [7:0]  rsp_out_priority;
   logic [7:0]  rsp_out_status;
   logic [15:0] rsp_out_amount;
   logic [7:0]  rsp_out_system_tag;
   logic [7:0]  rsp_out_resource_tag;
   logic [4:0]  rsp_occupancy;

   int mismatch_count;
   int replies_awaited;
   int stored_count;
   int popped_count;
   int empty_pop_count;
   int dropped_count;
   int idle_cycles = 0;

   stable_priority_event_queue u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_priority_req     (req_priority_req),
      .req_event_status     (req_event_status),
      .req_amount           (req_amount),
      .req_system_tag       (req_system_tag),
      .req_resource_tag     (req_resource_tag),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_out_priority     (rsp_out_priority),
      .rsp_out_status       (rsp_out_status),
      .rsp_out_amount       (rsp_out_amount),
      .rsp_out_system_tag   (rsp_out_system_tag),
      .rsp_out_resource_tag (rsp_out_resource_tag),
      .rsp_occupancy        (rsp_occupancy)
   );

   speq_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_priority_req     (req_priority_req),
      .req_event_status     (req_event_status),
      .req_amount           (req_amount),
      .req_system_tag       (req_system_tag),
      .req_resource_tag     (req_resource_tag),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_out_priority     (rsp_out_priority),
      .rsp_out_status       (rsp_out_status),
      .rsp_out_amount       (rsp_out_amount),
      .rsp_out_system_tag   (rsp_out_system_tag),
      .rsp_out_resource_tag (rsp_out_resource_tag),
      .rsp_occupancy        (rsp_occupancy),
      .mismatch_count       (mismatch_count),
      .replies_awaited      (replies_awaited),
      .stored_count         (stored_count),
      .popped_count         (popped_count),
      .empty_pop_count      (empty_pop_count),
      .dropped_count        (dropped_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_event(input logic kind, input entry_type ev);
      @(negedge clock);
      start            <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= ev.prio;
      req_event_status <= ev.status;
      req_amount       <= ev.amount;
      req_system_tag   <= ev.system_tag;
      req_resource_tag <= ev.resource_tag;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_until_answered();
      @(negedge clock);
      start <= 1'b0;
      while (replies_awaited != 0) @(negedge clock);
   endtask

   // Priorities are often drawn from a few values so that ties are frequent.
   function automatic entry_type random_event();
      entry_type ev;
      ev.status       = 8'($urandom);
      ev.amount       = 16'($urandom);
      ev.system_tag   = 8'($urandom);
      ev.resource_tag = 8'($urandom);
      case ($urandom_range(0, 3))
         0:       ev.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1:       ev.prio = 8'($urandom_range(0, 3) * 85);
         default: ev.prio = 8'($urandom);
      endcase
      return ev;
   endfunction

   initial begin
      entry_type ev;
      int        push_pct;
      bit        gaps_on;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_event(KIND_POP, '1);
      send_event(KIND_PUSH, '0);
      send_event(KIND_PUSH, '1);
      send_event(KIND_POP, '0);
      send_event(KIND_POP, '0);
      send_event(KIND_POP, '1);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ev.prio         = 8'((i % 4) * 85);
         ev.status       = 8'(i);
         ev.amount       = 16'(i * 4097);
         ev.system_tag   = 8'(i);
         ev.resource_tag = ~8'(i);
         send_event(KIND_PUSH, ev);
      end
      send_event(KIND_PUSH, '1);
      wait_until_answered();

      for (int phase = 0; phase < PHASES; phase++) begin
         push_pct = (phase % 2 == 0) ? 25 : 80;
         if (phase == 4) push_pct = 50;
         gaps_on = (phase < PHASES - 2) && ($urandom_range(0, 2) != 0);
         if (phase == PHASES / 2) wait_until_answered();
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 19));
            send_event(($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_POP,
                       random_event());
         end
      end

      wait_until_answered();
      repeat (4) @(posedge clock);
      $display("Summary: %0d transactions answered: %0d stored, %0d popped, %0d pops on empty,",
               stored_count + popped_count + empty_pop_count + dropped_count,
               stored_count, popped_count, empty_pop_count);
      $display("         %0d pushes dropped on a full queue, %0d mismatches.",
               dropped_count, mismatch_count);
      if (mismatch_count == 0 && replies_awaited == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
